### hdl/psi_dd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psi_dd_pkg;

  localparam int MAX_BINS    = 16;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int EDGE_N      = MAX_BINS + 1;
  localparam int EDGE_IW     = $clog2(EDGE_N);
  localparam int COUNT_WIDTH = 16;
  localparam int SEEN_W      = 16;
  localparam int EPSILON_Q16 = 1;
  localparam int LN2_Q16     = 45426;
  // log operand: cur or reference, both below 2^18
  localparam int VAL_W       = 18;
  localparam int EXP_W       = 5;
  localparam int FRAC_W      = 16;
  localparam int LOG_W       = EXP_W + FRAC_W;
  localparam int STAT_W      = 32;
  localparam int IN_DATA_W   = 86;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_EDGE   = 2'd1,
    OP_REF    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_BINS   = 2'd0,
    CFG_BLEN   = 2'd1,
    CFG_THR    = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_e;

  typedef struct packed {
    logic             capture;
    logic             bin_calc;
    logic             incr;
    logic             div_init;
    logic             div_step;
    logic             log_init;
    logic             log_ref;
    logic             log_step;
    logic             mul_p1;
    logic             mul_hi;
    logic             mul_lo;
    logic             accum;
    logic             finish;
    logic             out_load;
    logic [BIN_W-1:0] bin_idx;
  } cmd_t;

  typedef struct packed {
    logic end_hit;
    logic last_bin;
    logic out_free;
  } sts_t;

  // position of the leading one, zero for a zero operand
  function automatic logic [EXP_W-1:0] lead_pos(input logic [VAL_W-1:0] v);
    logic [EXP_W-1:0] p;
    p = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (v[i]) p = EXP_W'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### hdl/psi_dd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module psi_dd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  input  psi_dd_pkg::sts_t     sts_i,
  output psi_dd_pkg::cmd_t     cmd_o
);
  import psi_dd_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_BIN   = 15'b000000000000010,
    ST_INC   = 15'b000000000000100,
    ST_DIVI  = 15'b000000000001000,
    ST_DIV   = 15'b000000000010000,
    ST_LOGI  = 15'b000000000100000,
    ST_LOGC  = 15'b000000001000000,
    ST_LOGRI = 15'b000000010000000,
    ST_LOGR  = 15'b000000100000000,
    ST_MUL1  = 15'b000001000000000,
    ST_MUL2  = 15'b000010000000000,
    ST_MUL3  = 15'b000100000000000,
    ST_ACC   = 15'b001000000000000,
    ST_FIN   = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [BIN_W-1:0] k_q, k_d;
  logic             last_step;

  assign last_step = (step_q == 4'hF);

  // sequence one item, and the per-bin evaluation at block end
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    k_d         = k_q;
    cmd_o       = '0;
    cmd_o.bin_idx = k_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (op_e'(in_op_i) == OP_SAMPLE) ? ST_BIN : ST_OUT;
        end
      end
      ST_BIN: begin
        cmd_o.bin_calc = 1'b1;
        state_d = ST_INC;
      end
      ST_INC: begin
        cmd_o.incr = 1'b1;
        k_d = '0;
        state_d = sts_i.end_hit ? ST_DIVI : ST_OUT;
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 4'd1;
        if (last_step) state_d = ST_LOGI;
      end
      ST_LOGI: begin
        cmd_o.log_init = 1'b1;
        state_d = ST_LOGC;
      end
      ST_LOGC: begin
        cmd_o.log_step = 1'b1;
        step_d = step_q + 4'd1;
        if (last_step) state_d = ST_LOGRI;
      end
      ST_LOGRI: begin
        cmd_o.log_init = 1'b1;
        cmd_o.log_ref  = 1'b1;
        state_d = ST_LOGR;
      end
      ST_LOGR: begin
        cmd_o.log_step = 1'b1;
        step_d = step_q + 4'd1;
        if (last_step) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_p1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_hi = 1'b1;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul_lo = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        if (sts_i.last_bin) begin
          state_d = ST_FIN;
        end else begin
          k_d = k_q + 1'b1;
          state_d = ST_DIVI;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      k_q     <= k_d;
    end
  end

endmodule
`default_nettype wire

### hdl/psi_dd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module psi_dd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  psi_dd_pkg::cmd_t                   cmd_i,
  output psi_dd_pkg::sts_t                   sts_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic [psi_dd_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic [1:0]                         in_op_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_flag_o,
  output logic                               out_end_o,
  output logic [psi_dd_pkg::STAT_W-1:0]      out_stat_o
);
  import psi_dd_pkg::*;

  // configuration
  logic [4:0]        bins_q;
  logic [SEEN_W-1:0] blen_q;
  logic [31:0]       thr_q;
  logic [4:0]        bins_wr;

  always_comb begin
    bins_wr = cfg_data_i[4:0];
    if (bins_wr == 5'd0) bins_wr = 5'd1;
    if (bins_wr > 5'(MAX_BINS)) bins_wr = 5'(MAX_BINS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= 5'(MAX_BINS);
      blen_q <= 16'd1000;
      thr_q  <= 32'd16384;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_BINS: bins_q <= bins_wr;
        CFG_BLEN: blen_q <= cfg_data_i[SEEN_W-1:0];
        CFG_THR:  thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input beat fields
  logic signed [31:0] in_sample, in_edge;
  logic [4:0]         in_idx;
  logic [16:0]        in_prob;
  assign in_sample = in_data_i[31:0];
  assign in_idx    = in_data_i[36:32];
  assign in_edge   = in_data_i[68:37];
  assign in_prob   = in_data_i[85:69];

  // tables and captured sample
  logic signed [31:0] edge_q [EDGE_N];
  logic [16:0]        ref_q [MAX_BINS];
  logic signed [31:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= in_sample;
      if (op_e'(in_op_i) == OP_EDGE && in_idx <= 5'(MAX_BINS))
        edge_q[in_idx[EDGE_IW-1:0]] <= in_edge;
      if (op_e'(in_op_i) == OP_REF && in_idx < 5'(MAX_BINS))
        ref_q[in_idx[BIN_W-1:0]] <= in_prob;
    end
  end

  // bin select: count edges at or below the sample
  logic [EDGE_N-1:0] le_mask;
  logic [4:0]        n_le, bin_sel;
  logic [BIN_W-1:0]  bin_q;

  always_comb begin
    for (int i = 0; i < EDGE_N; i++)
      le_mask[i] = (5'(i) <= bins_q) && (edge_q[i] <= sample_q);
    n_le    = 5'($countones(le_mask));
    bin_sel = (n_le == 5'd0) ? 5'd0 : n_le - 5'd1;
    if (bin_sel > bins_q - 5'd1) bin_sel = bins_q - 5'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_calc) bin_q <= bin_sel[BIN_W-1:0];
  end

  // counts and samples seen
  logic [COUNT_WIDTH-1:0] cnt_q [MAX_BINS];
  logic [BIN_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [SEEN_W-1:0]      seen_q, seen_nxt, limit;

  assign rd_addr  = cmd_i.incr ? bin_q : cmd_i.bin_idx;
  assign cnt_rd   = cnt_q[rd_addr];
  assign seen_nxt = seen_q + 16'd1;
  assign limit    = (blen_q == '0) ? 16'd1 : blen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BINS; i++) cnt_q[i] <= '0;
      seen_q <= '0;
    end else if (cmd_i.finish) begin
      for (int i = 0; i < MAX_BINS; i++) cnt_q[i] <= '0;
      seen_q <= '0;
    end else if (cmd_i.incr) begin
      cnt_q[bin_q] <= cnt_rd + 1'b1;
      seen_q <= seen_nxt;
    end
  end

  // restoring division: count * 2^16 / seen, one quotient bit a cycle
  logic [16:0]      div_r_q, div_q_q, sd, r_in, r_sub;
  logic             geq;
  logic [VAL_W-1:0] cur;

  assign sd = (seen_q == '0) ? 17'd1 : {1'b0, seen_q};

  always_comb begin
    r_in  = cmd_i.div_init ? {1'b0, cnt_rd} : {div_r_q[15:0], 1'b0};
    geq   = (r_in >= sd);
    r_sub = r_in - sd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      div_r_q <= geq ? r_sub : r_in;
      div_q_q <= {16'd0, geq};
    end else if (cmd_i.div_step) begin
      div_r_q <= geq ? r_sub : r_in;
      div_q_q <= {div_q_q[15:0], geq};
    end
  end

  assign cur = {1'b0, div_q_q} + VAL_W'(EPSILON_Q16);

  // log2 by repeated squaring of the normalized mantissa
  logic [VAL_W-1:0]  refx, log_v;
  logic [EXP_W-1:0]  log_e_q, lead;
  logic [31:0]       log_m_q;
  logic [FRAC_W-1:0] log_f_q;
  logic [LOG_W-1:0]  la_q, lb;
  logic [63:0]       sq;
  logic [32:0]       sq_t;
  logic              zero_q;

  assign refx  = {1'b0, ref_q[cmd_i.bin_idx]};
  assign log_v = cmd_i.log_ref ? refx : cur;
  assign lead  = lead_pos(log_v);
  assign sq    = {32'd0, log_m_q} * {32'd0, log_m_q};
  assign sq_t  = sq[63:31];
  assign lb    = {log_e_q, log_f_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_init) begin
      log_e_q <= lead;
      log_m_q <= 32'(log_v) << (5'd31 - lead);
      log_f_q <= '0;
      if (cmd_i.log_ref) la_q <= {log_e_q, log_f_q};
    end else if (cmd_i.log_step) begin
      log_m_q <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
      log_f_q <= {log_f_q[FRAC_W-2:0], sq_t[32]};
    end
  end

  // term = |cur-ref| * |log diff| * ln2 >> 32, product split in two halves
  logic [LOG_W-1:0]  dl;
  logic [VAL_W-1:0]  dc, dc_q;
  logic [36:0]       p1_q, hi_prod;
  logic [35:0]       lo_prod;
  logic [54:0]       acc_q;
  logic [31:0]       sum_q, last_q;
  logic [32:0]       sum_nxt;
  logic              sat_q, end_q;

  assign dl      = (la_q >= lb) ? la_q - lb : lb - la_q;
  assign dc      = (cur >= refx) ? cur - refx : refx - cur;
  assign hi_prod = 37'(p1_q[36:18]) * 37'(dc_q);
  assign lo_prod = 36'(p1_q[17:0]) * 36'(dc_q);
  assign sum_nxt = {1'b0, sum_q} + 33'(acc_q[54:32]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_p1) begin
      p1_q <= 37'(dl) * 37'(LN2_Q16);
      dc_q <= dc;
    end
    if (cmd_i.mul_hi) acc_q <= 55'(hi_prod) << 18;
    else if (cmd_i.mul_lo) acc_q <= acc_q + 55'(lo_prod);
  end

  // accumulate, saturate, and close the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      sat_q  <= 1'b0;
      zero_q <= 1'b0;
      last_q <= '0;
      end_q  <= 1'b0;
    end else begin
      if (cmd_i.incr) begin
        sum_q  <= '0;
        sat_q  <= 1'b0;
        zero_q <= 1'b0;
      end
      if (cmd_i.log_init && log_v == '0) zero_q <= 1'b1;
      if (cmd_i.accum) begin
        sum_q <= sum_nxt[31:0];
        if (sum_nxt[32] || zero_q) sat_q <= 1'b1;
      end
      if (cmd_i.capture) end_q <= 1'b0;
      if (cmd_i.finish) begin
        last_q <= sat_q ? '1 : sum_q;
        end_q  <= 1'b1;
      end
    end
  end

  // output register
  logic out_valid_q, out_flag_q, out_end_q;
  logic [STAT_W-1:0] out_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_flag_q <= end_q && (last_q > thr_q);
      out_end_q  <= end_q;
      out_stat_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_flag_o  = out_flag_q;
  assign out_end_o   = out_end_q;
  assign out_stat_o  = out_stat_q;

  assign sts_o.end_hit  = (seen_nxt >= limit);
  assign sts_o.last_bin = ({1'b0, cmd_i.bin_idx} == bins_q - 5'd1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

### hdl/psi_drift_detector_unit.sv
// Population stability index drift detector.
// Input stream: one beat is a sample, an edge-table load or a reference
// probability load, selected by s_axis_tuser. Output stream: exactly one beat
// per input beat, carrying the last block statistic; tlast marks the beat of
// a sample that closed a block, tuser flags drift on that beat.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 bins in use, 1 block length, 2 threshold) in the same cycle.
// Timing: a load beat goes from accept straight to the output register, a
// sample first through bin select and count update; the input is ready again
// once the result is loaded. A sample that closes a block adds per bin in use
// a restoring divider pass, two log2 squaring passes on one shared 32x32
// multiplier, and the product, high-half, low-half and accumulate steps, then a final step that closes the block.
// One item is in work at a time; the next beat is taken once the result is
// in the output register, even if that register still waits on m_axis_tready.
// A stalled receiver holds the output beat and stops the block after it.
// Reset: counts, samples seen and the statistic clear, configuration returns
// to 16 bins, block length 1000, threshold 0.25; table entries are undefined
// until loaded.
`timescale 1ns / 1ps
`default_nettype none
module psi_drift_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_value[31:0], table_index[36:32], edge_value[68:37],
  // reference_probability[85:69], zero fill[87:86]
  input  logic [87:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // statistic[31:0]
  output logic [31:0] m_axis_tdata,
  // drift_flag[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import psi_dd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psi_dd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psi_dd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata[IN_DATA_W-1:0]),
    .in_op_i     (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_flag_o  (m_axis_tuser),
    .out_end_o   (m_axis_tlast),
    .out_stat_o  (m_axis_tdata)
  );

  // drift is only reported on the beat that closes a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("drift flag without block end");

  // one item in work: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a new result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output beat overwritten");

endmodule
`default_nettype wire

### tb/tb_psi_drift_detector_unit.sv
`timescale 1ns / 1ps
module tb_psi_drift_detector_unit;
  import psi_dd_pkg::*;

  typedef struct packed {
    logic        drift;
    logic        closed;
    logic [31:0] stat;
  } psi_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_NOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_BINS;
  logic [31:0] cfg_data_i = '0;

  psi_drift_detector_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  int unsigned        bins_q = 16;
  int unsigned        blen_q = 1000;
  logic [31:0]        thr_q = 32'd16384;
  logic [15:0]        counts_q [MAX_BINS];
  logic [15:0]        seen_q = '0;
  logic [31:0]        stat_q = '0;
  logic signed [31:0] edges_q [MAX_BINS+1];
  logic [16:0]        probs_q [MAX_BINS];

  psi_result_t expected_q [$];
  int          errors = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;

  initial begin
    foreach (counts_q[i]) counts_q[i] = '0;
  end

  // log2 in Q16: integer part plus 16 bits from repeated squaring
  function automatic logic [63:0] log2_fix(logic [63:0] v);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    e = 0;
    frac = '0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic logic [31:0] psi_of_block();
    logic [63:0] total, cur, pr, dc, dl, la, lb;
    total = '0;
    for (int i = 0; i < bins_q; i++) begin
      cur = ((64'(counts_q[i]) << 16) / 64'(seen_q)) + EPSILON_Q16;
      pr  = 64'(probs_q[i]);
      if (cur == 0 || pr == 0) return 32'hFFFF_FFFF;
      dc = (cur >= pr) ? cur - pr : pr - cur;
      la = log2_fix(cur);
      lb = log2_fix(pr);
      dl = (la >= lb) ? la - lb : lb - la;
      total += (dc * dl * LN2_Q16) >> 32;
      if (total > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    end
    return total[31:0];
  endfunction

  // advance the predictor by one accepted beat and queue its result
  task automatic predict_beat(op_e op, logic signed [31:0] smp, logic [4:0] idx,
                              logic signed [31:0] edgev, logic [16:0] prob);
    psi_result_t r;
    int          hits;
    int          b;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        hits = 0;
        for (int i = 0; i <= bins_q; i++) if (edges_q[i] <= smp) hits++;
        b = (hits == 0) ? 0 : hits - 1;
        if (b > bins_q - 1) b = bins_q - 1;
        counts_q[b] = counts_q[b] + 1'b1;
        seen_q = seen_q + 1'b1;
        if (seen_q >= ((blen_q == 0) ? 1 : blen_q)) begin
          stat_q = psi_of_block();
          r.drift = stat_q > thr_q;
          r.closed = 1'b1;
          foreach (counts_q[i]) counts_q[i] = '0;
          seen_q = '0;
        end
      end
      OP_EDGE: if (idx <= MAX_BINS) edges_q[idx] = edgev;
      OP_REF:  if (idx < MAX_BINS) probs_q[idx] = prob;
      default: ;
    endcase
    r.stat = stat_q;
    expected_q.push_back(r);
  endtask

  // offer one beat, optionally after a random gap, and hold it until taken
  task automatic send_beat(op_e op, logic [31:0] smp, logic [4:0] idx,
                           logic [31:0] edgev, logic [16:0] prob);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, prob, edgev, idx, smp};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    predict_beat(op, smp, idx, edgev, prob);
  endtask

  task automatic send_sample(logic [31:0] smp);
    send_beat(OP_SAMPLE, smp, 5'($urandom), $urandom, 17'($urandom));
  endtask

  // wait until every queued result has arrived and the block is idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_BINS: begin
        bins_q = val[4:0];
        if (bins_q < 1) bins_q = 1;
        if (bins_q > MAX_BINS) bins_q = MAX_BINS;
      end
      CFG_BLEN: blen_q = val[15:0];
      CFG_THR:  thr_q = val;
      default: ;
    endcase
  endtask

  // ascending edge table with random spacing, plus random probabilities
  task automatic load_tables();
    logic signed [31:0] e;
    e = 32'sh8000_0000 + $urandom_range(0, 1 << 20);
    for (int i = 0; i <= MAX_BINS; i++) begin
      send_beat(OP_EDGE, $urandom, 5'(i), e, 17'($urandom));
      e = e + $urandom_range(1, 32'h0FFF_FFFF);
    end
    for (int i = 0; i < MAX_BINS; i++)
      send_beat(OP_REF, $urandom, 5'(i), $urandom, 17'($urandom_range(1, 65536)));
  endtask

  task automatic test_directed();
    load_tables();
    write_reg(CFG_BLEN, 32'd4);
    // field extremes, unsigned probability extremes, dead opcode
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_beat(OP_REF, 32'h0, 5'd3, 32'h0, 17'h1_0000);
    send_beat(OP_REF, 32'hFFFF_FFFF, 5'd5, 32'hFFFF_FFFF, 17'd1);
    send_beat(OP_NOP, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 17'h1_FFFF);
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    // out-of-range table indexes are dropped
    send_beat(OP_EDGE, 32'h0, 5'd17, 32'h1234_5678, 17'd9);
    send_beat(OP_EDGE, 32'h0, 5'd31, 32'h0, 17'd9);
    send_beat(OP_REF, 32'h0, 5'd16, 32'h0, 17'd0);
    send_beat(OP_REF, 32'h0, 5'd31, 32'h0, 17'h1_FFFF);
    // below the first edge and above a shrunk table clamp to the end bins
    write_reg(CFG_BINS, 32'd0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    write_reg(CFG_BINS, 32'd31);
    write_reg(CFG_BLEN, 32'd1);
    send_sample(32'h7FFF_FFFF);
    write_reg(CFG_THR, 32'd0);
    send_sample($urandom);
    write_reg(CFG_THR, 32'hFFFF_FFFF);
    send_sample($urandom);
    write_reg(CFG_BLEN, 32'd0);
    send_sample($urandom);
    // shrinking the block length closes the running block on the next sample
    write_reg(CFG_BLEN, 32'd65535);
    repeat (3) send_sample($urandom);
    write_reg(CFG_BLEN, 32'd2);
    send_sample($urandom);
    drain();
  endtask

  task automatic random_beat();
    int pick;
    logic signed [31:0] e;
    pick = $urandom_range(0, 99);
    if (pick < 86) begin
      send_sample($urandom);
    end else if (pick < 93) begin
      // move one edge between its neighbors to keep the table mostly ordered
      pick = $urandom_range(0, MAX_BINS);
      e = (pick == 0) ? 32'sh8000_0000 : edges_q[pick-1];
      if (pick < MAX_BINS && edges_q[pick+1] > e)
        e = e + 32'($urandom_range(0, edges_q[pick+1] - e));
      else
        e = $urandom;
      send_beat(OP_EDGE, $urandom, ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'(pick),
                e, 17'($urandom));
    end else if (pick < 97) begin
      send_beat(OP_REF, $urandom, 5'($urandom), $urandom, 17'($urandom_range(1, 65536)));
    end else begin
      send_beat(OP_NOP, $urandom, 5'($urandom), $urandom, 17'($urandom));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_BINS, (ph % 3 == 0) ? $urandom_range(1, 4) : $urandom_range(0, 31));
      write_reg(CFG_BLEN, $urandom_range(1, 10));
      write_reg(CFG_THR, (ph % 2) ? $urandom : $urandom_range(0, 1 << 18));
      repeat (110) random_beat();
    end
    drain();
  endtask

  // long receiver stall while items keep coming
  task automatic test_backpressure();
    write_reg(CFG_BLEN, 32'd3);
    hold_left = 400;
    repeat (12) random_beat();
    drain();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    write_reg(CFG_BINS, 32'd16);
    write_reg(CFG_BLEN, 32'd5);
    repeat (60) random_beat();
    drain();
  endtask

  // result checker and receiver stall pattern
  initial begin
    psi_result_t want;
    int          stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected beat: statistic %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser !== want.drift) begin
            $error("drift_flag: expected %0d, got %0d", want.drift, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== want.closed) begin
            $error("block_end: expected %0d, got %0d", want.closed, m_axis_tlast);
            errors++;
          end
          if (m_axis_tdata !== want.stat) begin
            $error("statistic: expected %h, got %h", want.stat, m_axis_tdata);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_quiet_tail();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_psi_drift_detector_unit: PASS");
    end else begin
      $display("tb_psi_drift_detector_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_psi_drift_detector_unit: FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/psi_dd_pkg.sv
hdl/psi_dd_ctrl.sv
hdl/psi_dd_datapath.sv
hdl/psi_drift_detector_unit.sv
tb/tb_psi_drift_detector_unit.sv
